// ----- hdl/mft_pkg.sv -----
// Package: constants and register map for the Manchester frame transmitter.
package mft_pkg;

	localparam int BYTE_W           = 8;
	localparam int IDX_W            = 5;
	localparam int PCLK_W           = 24;
	localparam int SYNC_HIGH_PULSES = 3;
	localparam int SYNC_PULSES      = SYNC_HIGH_PULSES + 1;
	localparam int DATA_BITS_DEF    = 8;
	localparam int APB_AW           = 3;
	localparam int APB_DW           = 32;

	localparam logic [PCLK_W-1:0] PCLK_RESET = PCLK_W'(25000);

	typedef enum logic [0:0] {
		REG_PULSE_CLOCKS = 1'b0
	} reg_idx_t;

endpackage

// ----- hdl/manchester_frame_transmitter.sv -----
// Top level: byte to Manchester frame sequencer with APB configuration.
//
// Usage:
//   Input channel (data_byte, in_valid/in_ready) takes one byte per transfer.
//   Each byte is sent as a frame of 4 + 2*DATA_BITS pulses (20 for 8 bits):
//   sync high, high, high, low, then Manchester pairs, bit 0 first
//   (1 = high,low; 0 = low,high). Output channel (line_level, pulse_index,
//   last, out_valid/out_ready) carries one transfer per pulse.
//   Pulses are spaced by pulse_clocks (0 counts as 1), set from
//   the APB register at address 0; reset value 25000.
//   A byte passes the input register, the sequencer and the output register
//   before its first pulse appears, when the sequencer is free and the
//   previous pulse has run out. The byte rate is set by the pulse timer.
//   A one-entry input register lets the next byte be taken while a frame is
//   still being sent; the next frame starts right after the last pulse.
//   If the receiver stalls, the pending pulse is held in the output register
//   and the sequencer waits; nothing is lost.
//   Reset clears all control state and loads pulse_clocks with 25000.
module manchester_frame_transmitter
	import mft_pkg::*;
#(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              line_level,
	output logic [IDX_W-1:0]  pulse_index,
	output logic              last,
	output logic              out_valid,
	input  logic              out_ready
);

	localparam int FRAME_PULSES = SYNC_PULSES + 2 * DATA_BITS;
	localparam int POS_W        = $clog2(FRAME_PULSES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_PULSES - 1);
	localparam logic [POS_W-1:0] POS_SYNC_LOW = POS_W'(SYNC_HIGH_PULSES);

	logic [PCLK_W-1:0]    pclk_q;
	logic                 in_full_q;
	logic [BYTE_W-1:0]    in_data_q;
	logic                 act_q;
	logic [POS_W-1:0]     pos_q;
	logic [DATA_BITS-1:0] shift_q;
	logic [PCLK_W-1:0]    timer_q;

	logic                 step;
	logic                 load;
	logic                 pos_is_last;
	logic                 level;
	logic [DATA_BITS-1:0] load_bits;
	logic [PCLK_W-1:0]    timer_reload;
	logic                 cfg_wr;
	reg_idx_t             cfg_idx;

	// APB
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[APB_AW-1]);
	assign cfg_wr  = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pclk_q <= PCLK_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_PULSE_CLOCKS: pclk_q <= pwdata[PCLK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_PULSE_CLOCKS: prdata = APB_DW'(pclk_q);
			default:          prdata = '0;
		endcase
	end

	// sequencer
	assign pos_is_last  = (pos_q == POS_LAST);
	assign step         = act_q && (timer_q == '0) && (!out_valid || out_ready);
	assign load         = in_full_q && (!act_q || (step && pos_is_last));
	assign in_ready     = !in_full_q || load;
	assign timer_reload = (pclk_q == '0) ? '0 : pclk_q - PCLK_W'(1);

	always_comb begin
		for (int i = 0; i < DATA_BITS; i++) begin
			load_bits[i] = (i < BYTE_W) ? in_data_q[i % BYTE_W] : 1'b0;
		end
	end

	always_comb begin
		if (pos_q < POS_SYNC_LOW) begin
			level = 1'b1;
		end else if (pos_q == POS_SYNC_LOW) begin
			level = 1'b0;
		end else begin
			level = shift_q[0] ^ pos_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_full_q <= 1'b0;
			act_q     <= 1'b0;
			pos_q     <= '0;
			timer_q   <= '0;
		end else begin
			if (in_valid && in_ready) begin
				in_full_q <= 1'b1;
			end else if (load) begin
				in_full_q <= 1'b0;
			end
			if (load) begin
				act_q <= 1'b1;
				pos_q <= '0;
			end else if (step) begin
				if (pos_is_last) begin
					act_q <= 1'b0;
				end
				pos_q <= pos_q + POS_W'(1);
			end
			// timer keeps running after the frame so the last pulse holds its length
			if (step) begin
				timer_q <= timer_reload;
			end else if (timer_q != '0) begin
				timer_q <= timer_q - PCLK_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_data_q <= data_byte;
		end
		if (load) begin
			shift_q <= load_bits;
		end else if (step && pos_q > POS_SYNC_LOW && pos_q[0]) begin
			shift_q <= shift_q >> 1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			line_level  <= level;
			pulse_index <= IDX_W'(pos_q);
			last        <= pos_is_last;
		end
	end

	// checks
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_full_q && !act_q |=> act_q)
		else $error("pending byte not loaded into idle sequencer");

	a_sync_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_index < IDX_W'(SYNC_HIGH_PULSES) |-> line_level)
		else $error("sync pulse not high");

	a_sync_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_index == IDX_W'(SYNC_HIGH_PULSES) |-> !line_level)
		else $error("sync low pulse not low");

	a_step_active: assert property (@(posedge clk) disable iff (!arst_n)
		step && pos_is_last && !load |=> !act_q)
		else $error("sequencer still active after last pulse");

endmodule

// ----- sim/manchester_frame_transmitter_tb.sv -----
// Testbench for the Manchester frame transmitter: frames checked pulse by pulse.
module manchester_frame_transmitter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mft_pkg::*;

	localparam int DATA_BITS     = DATA_BITS_DEF;
	localparam int FRAME_PULSES  = SYNC_PULSES + 2 * DATA_BITS;
	localparam int REG_COUNT     = 1;
	localparam int STALL_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 200;

	localparam logic [APB_AW-1:0] ADDR_PCLK         = APB_AW'(4 * int'(REG_PULSE_CLOCKS));
	localparam logic [APB_AW-1:0] ADDR_UNMAPPED     = APB_AW'(4 * REG_COUNT);
	localparam logic [APB_AW-1:0] ADDR_UNMAPPED_TOP = APB_AW'(4 * REG_COUNT + 3);

	typedef struct packed {
		logic             level;
		logic [IDX_W-1:0] idx;
		logic             last;
	} pulse_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic              line_level;
	logic [IDX_W-1:0]  pulse_index;
	logic              last;
	logic              out_valid;
	logic              out_ready = 1'b0;

	pulse_t            pending_pulses[$];
	logic [PCLK_W-1:0] pulse_clocks_shadow;
	int                errors        = 0;
	int                stall_cycles  = 0;
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;

	manchester_frame_transmitter #(.DATA_BITS(DATA_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.data_byte(data_byte),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.line_level(line_level),
		.pulse_index(pulse_index),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	always #2 clk = ~clk;

	task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
		errors++;
	endtask

	// sync: high x3, low; then per bit (LSB first) bit, ~bit
	task queue_frame_pulses(input logic [BYTE_W-1:0] b);
		pulse_t p;
		logic   bit_v;
		int     k;
		for (int n = 0; n < FRAME_PULSES; n++) begin
			if (n < SYNC_PULSES) begin
				p.level = (n < SYNC_HIGH_PULSES);
			end else begin
				k = (n - SYNC_PULSES) / 2;
				bit_v = (k < BYTE_W) ? b[k] : 1'b0;
				p.level = ((n - SYNC_PULSES) % 2 == 0) ? bit_v : ~bit_v;
			end
			p.idx = IDX_W'(n);
			p.last = (n == FRAME_PULSES - 1);
			pending_pulses.push_back(p);
		end
	endtask

	task write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_PCLK)
			pulse_clocks_shadow = data[PCLK_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task check_pulse_clocks;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_PCLK;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[PCLK_W-1:0] !== pulse_clocks_shadow)
			report_mismatch("pulse_clocks readback", prdata[PCLK_W-1:0], pulse_clocks_shadow);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task set_pulse_clocks(input logic [APB_DW-1:0] value);
		write_reg(ADDR_PCLK, value);
		check_pulse_clocks();
	endtask

	task send_byte(input logic [BYTE_W-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		data_byte <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		queue_frame_pulses(b);
	endtask

	task wait_drained;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pulses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task test_reset_value;
		pulse_clocks_shadow = PCLK_RESET;
		check_pulse_clocks();
	endtask

	task test_register_access;
		set_pulse_clocks('1);
		write_reg(ADDR_UNMAPPED, 32'h0000_0005);
		check_pulse_clocks();
		write_reg(ADDR_UNMAPPED_TOP, '0);
		check_pulse_clocks();
		set_pulse_clocks('0);
	endtask

	task test_directed_frames;
		logic [BYTE_W-1:0] corner_bytes[8] = '{8'h00, 8'hFF, 8'h01, 8'h80,
			8'h55, 8'hAA, 8'h0F, 8'hF0};
		logic [BYTE_W-1:0] pattern_bytes[4] = '{8'h3C, 8'hC3, 8'h7E, 8'h81};
		// pulse_clocks of zero counts as one
		set_pulse_clocks('0);
		foreach (corner_bytes[i]) begin
			send_byte(corner_bytes[i]);
			if (i == 1)
				wait_drained();
		end
		wait_drained();
		set_pulse_clocks(32'd1);
		foreach (pattern_bytes[i])
			send_byte(pattern_bytes[i]);
		wait_drained();
		set_pulse_clocks(32'd40);
		repeat (2) send_byte(BYTE_W'($urandom));
		wait_drained();
	endtask

	task test_random_frames(input int sender_idle, input int receiver_idle);
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		for (int chunk = 0; chunk < 3; chunk++) begin
			wait_drained();
			set_pulse_clocks({8'($urandom),
				24'((chunk == 0) ? 1 : $urandom_range(0, 6))});
			repeat (22) send_byte(BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		pulse_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pulses.size() == 0) begin
				report_mismatch("unexpected pulse, index", pulse_index, '0);
			end else begin
				want = pending_pulses.pop_front();
				if (line_level !== want.level)
					report_mismatch("line_level", line_level, want.level);
				if (pulse_index !== want.idx)
					report_mismatch("pulse_index", pulse_index, want.idx);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	// no transfer on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles = stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_value();
		test_register_access();
		test_directed_frames();
		test_random_frames(19, 87);
		test_random_frames(87, 19);
		test_random_frames(0, 0);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/mft_pkg.sv
hdl/manchester_frame_transmitter.sv
sim/manchester_frame_transmitter_tb.sv
